[sv/fdpq_pkg.sv]
// Shared types and constants for the fetch-directed prefetch queue.
// Used by fdpq_fifo and fetch_directed_prefetch_queue; no dependencies.
package fdpq_pkg;

    // Default sizing
    localparam int TQ_DEPTH_DEF    = 8;
    localparam int PFQ_DEPTH_DEF   = 16;
    localparam int BLOCK_BYTES_DEF = 64;
    localparam int MAX_BLOCKS_DEF  = 16;

    // Fixed field widths
    localparam int ADDR_W  = 48;
    localparam int TGT_W   = 16;
    localparam int SLOT_W  = 3;
    localparam int IDATA_W = 176;
    localparam int ODATA_W = 120;

    // Request types
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_DONE   = 2'd2;
    localparam logic [1:0] REQ_POP    = 2'd3;

    // Result kinds
    localparam logic [1:0] RES_XLATE = 2'd0;
    localparam logic [1:0] RES_ISSUE = 2'd1;
    localparam logic [1:0] RES_EMPTY = 2'd2;

    // Register indexes
    localparam logic [2:0] CFG_MIN_DISTANCE = 3'd0;
    localparam logic [2:0] CFG_BLOCK_LIMIT  = 3'd1;
    localparam logic [2:0] CFG_SKIP_FIRST   = 3'd2;
    localparam logic [2:0] CFG_SQUASH       = 3'd3;
    localparam logic [2:0] CFG_SNOOP        = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_SQUASH,
        ST_POP
    } state_t;

    // Commands into the prefetch FIFO
    typedef struct packed {
        logic push;
        logic pop;
        logic del;
    } fifo_cmd_t;

    // Status from the prefetch FIFO
    typedef struct packed {
        logic hit;
        logic del_hit;
        logic empty;
        logic full;
    } fifo_stat_t;

endpackage

[sv/fetch_directed_prefetch_queue.sv]
// Fetch-directed instruction prefetch queue: one beat at a time.
// Insert: walks the range block by block against the table and the FIFO, holding
//   while the output register is full. Remove: deletes the target's FIFO entries.
// Pop: returns the FIFO head or an empty result. Completion: handled on acceptance.
// Reset clears control state, slot valid bits and the FIFO count; no clearing pass.
// Depends on fdpq_pkg and fdpq_fifo.
module fetch_directed_prefetch_queue #(
    parameter int TQ_DEPTH    = fdpq_pkg::TQ_DEPTH_DEF,
    parameter int PFQ_DEPTH   = fdpq_pkg::PFQ_DEPTH_DEF,
    parameter int BLOCK_BYTES = fdpq_pkg::BLOCK_BYTES_DEF,
    parameter int MAX_BLOCKS  = fdpq_pkg::MAX_BLOCKS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // start_pc, end_pc, head_distance, target_id, tq_slot, failed,
    // phys_addr, uncacheable, outside_memory, already_cached, zero pad
    input  logic [fdpq_pkg::IDATA_W-1:0]   s_tdata,
    // req_type
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // virt_addr, phys_out, slot_out, target_out, zero pad
    output logic [fdpq_pkg::ODATA_W-1:0]   m_tdata,
    // result_kind
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [2:0]                     cfg_index,
    input  logic [7:0]                     cfg_data
);
    localparam int AW  = fdpq_pkg::ADDR_W;
    localparam int TW  = fdpq_pkg::TGT_W;
    localparam int SW  = fdpq_pkg::SLOT_W;
    localparam int SH  = $clog2(BLOCK_BYTES);
    localparam int BN  = AW - SH;
    localparam int BW  = BN + 1;
    localparam int TIW = (TQ_DEPTH > 1) ? $clog2(TQ_DEPTH) : 1;
    localparam int LW  = $clog2(MAX_BLOCKS + 1);
    localparam int CW  = $clog2(PFQ_DEPTH + 1);

    // Input fields
    logic [AW-1:0] in_start, in_end, in_phys;
    logic [7:0]    in_head;
    logic [TW-1:0] in_tgt;
    logic [SW-1:0] in_slot;
    logic          in_failed, in_uncache, in_outside, in_cached;

    assign in_start   = s_tdata[47:0];
    assign in_end     = s_tdata[95:48];
    assign in_head    = s_tdata[103:96];
    assign in_tgt     = s_tdata[119:104];
    assign in_slot    = s_tdata[122:120];
    assign in_failed  = s_tdata[123];
    assign in_phys    = s_tdata[171:124];
    assign in_uncache = s_tdata[172];
    assign in_outside = s_tdata[173];
    assign in_cached  = s_tdata[174];

    // Configuration registers
    logic [7:0] min_dist_reg;
    logic [4:0] blk_limit_reg;
    logic       skip_reg, squash_reg, snoop_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_dist_reg  <= '0;
            blk_limit_reg <= '0;
            skip_reg      <= 1'b0;
            squash_reg    <= 1'b1;
            snoop_reg     <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                fdpq_pkg::CFG_MIN_DISTANCE: min_dist_reg  <= cfg_data;
                fdpq_pkg::CFG_BLOCK_LIMIT:  blk_limit_reg <= cfg_data[4:0];
                fdpq_pkg::CFG_SKIP_FIRST:   skip_reg      <= cfg_data[0];
                fdpq_pkg::CFG_SQUASH:       squash_reg    <= cfg_data[0];
                fdpq_pkg::CFG_SNOOP:        snoop_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Translation table
    logic [TQ_DEPTH-1:0] tq_valid_reg, tq_valid_next;
    logic [BN-1:0]       tq_block_reg  [TQ_DEPTH];
    logic [TW-1:0]       tq_target_reg [TQ_DEPTH];
    logic [TQ_DEPTH-1:0] tq_cancel_reg;

    // Sequencer and walk registers
    fdpq_pkg::state_t state_reg, state_next;
    logic [BW-1:0] blk_reg, blk_next;
    logic [BN-1:0] end_blk_reg, end_blk_next;
    logic [LW-1:0] left_reg, left_next;
    logic [TW-1:0] tgt_reg, tgt_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic [SW-1:0] pend_slot_reg, pend_slot_next;

    // Output register
    logic          out_valid_reg;
    logic [1:0]    out_kind_reg;
    logic [AW-1:0] out_va_reg, out_pa_reg;
    logic [SW-1:0] out_slot_reg;
    logic [TW-1:0] out_tgt_reg;
    logic          out_last_reg;

    logic          out_load;
    logic [1:0]    out_kind;
    logic [AW-1:0] out_va, out_pa;
    logic [SW-1:0] out_slot;
    logic [TW-1:0] out_tgt;
    logic          out_last;
    logic          out_free;

    // FIFO
    fdpq_pkg::fifo_cmd_t  fcmd;
    fdpq_pkg::fifo_stat_t fstat;
    logic [BN-1:0]        head_v, head_p;
    logic [TW-1:0]        head_t;
    logic [CW-1:0]        fcount;

    // Walk compare and slot choice
    logic [BN-1:0]  query;
    logic           tq_hit;
    logic           free_found;
    logic [TIW-1:0] free_idx;
    logic           walk_done;

    // Insert setup
    logic [AW-1:0]  last_byte;
    logic [BW-1:0]  first_blk;
    logic [LW-1:0]  limit;

    // Completion
    logic [6:0]     slot_ext;
    logic [TIW-1:0] done_idx;
    logic           done_ok;
    logic           done_keep;

    logic           accept;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == fdpq_pkg::ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    assign last_byte = (in_end <= in_start) ? in_start : in_end - AW'(1);
    assign first_blk = {1'b0, in_start[AW-1:SH]} + BW'(skip_reg);
    assign limit     = (blk_limit_reg == 5'd0 || 32'(blk_limit_reg) > MAX_BLOCKS)
                       ? LW'(MAX_BLOCKS) : LW'(blk_limit_reg);

    assign slot_ext  = {4'd0, in_slot};
    assign done_idx  = slot_ext[TIW-1:0];
    assign done_ok   = (32'(slot_ext) < TQ_DEPTH) && tq_valid_reg[done_idx];
    assign done_keep = !in_failed && !tq_cancel_reg[done_idx] && !in_uncache &&
                       !in_outside && !(snoop_reg && in_cached) && !fstat.full;

    assign query     = blk_reg[BN-1:0];
    assign walk_done = (blk_reg > {1'b0, end_blk_reg}) || (left_reg == '0);

    // Block compare against the table, lowest free slot
    always_comb
    begin
        tq_hit     = 1'b0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < TQ_DEPTH; i++)
        begin
            if (tq_valid_reg[i] && tq_block_reg[i] == query)
                tq_hit = 1'b1;
            if (!free_found && !tq_valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = TIW'(i);
            end
        end
    end

    // Sequencer next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        blk_next        = blk_reg;
        end_blk_next    = end_blk_reg;
        left_next       = left_reg;
        tgt_next        = tgt_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        pend_slot_next  = pend_slot_reg;
        tq_valid_next   = tq_valid_reg;
        fcmd            = '0;
        out_load        = 1'b0;
        out_kind        = fdpq_pkg::RES_XLATE;
        out_va          = pend_addr_reg;
        out_pa          = '0;
        out_slot        = pend_slot_reg;
        out_tgt         = tgt_reg;
        out_last        = 1'b0;

        unique case (state_reg)
            fdpq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (s_tuser)
                        fdpq_pkg::REQ_INSERT:
                        begin
                            if (in_head >= min_dist_reg)
                            begin
                                blk_next        = first_blk;
                                end_blk_next    = last_byte[AW-1:SH];
                                left_next       = limit;
                                tgt_next        = in_tgt;
                                pend_valid_next = 1'b0;
                                state_next      = fdpq_pkg::ST_WALK;
                            end
                        end
                        fdpq_pkg::REQ_REMOVE:
                        begin
                            if (squash_reg)
                            begin
                                tgt_next   = in_tgt;
                                state_next = fdpq_pkg::ST_SQUASH;
                            end
                        end
                        fdpq_pkg::REQ_DONE:
                        begin
                            if (done_ok)
                            begin
                                fcmd.push               = done_keep;
                                tq_valid_next[done_idx] = 1'b0;
                            end
                        end
                        fdpq_pkg::REQ_POP:
                            state_next = fdpq_pkg::ST_POP;
                        default: ;
                    endcase
                end
            end
            fdpq_pkg::ST_WALK:
            begin
                if (out_free)
                begin
                    if (walk_done)
                    begin
                        out_load        = pend_valid_reg;
                        out_last        = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = fdpq_pkg::ST_IDLE;
                    end
                    else
                    begin
                        blk_next  = blk_reg + BW'(1);
                        left_next = left_reg - LW'(1);
                        if (!tq_hit && !fstat.hit && free_found)
                        begin
                            tq_valid_next[free_idx] = 1'b1;
                            out_load        = pend_valid_reg;
                            pend_valid_next = 1'b1;
                            pend_addr_next  = {query, {SH{1'b0}}};
                            pend_slot_next  = SW'({{(7 - TIW){1'b0}}, free_idx});
                        end
                    end
                end
            end
            fdpq_pkg::ST_SQUASH:
            begin
                fcmd.del = 1'b1;
                if (!fstat.del_hit)
                    state_next = fdpq_pkg::ST_IDLE;
            end
            fdpq_pkg::ST_POP:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_last   = 1'b1;
                    out_slot   = '0;
                    state_next = fdpq_pkg::ST_IDLE;
                    if (fstat.empty)
                    begin
                        out_kind = fdpq_pkg::RES_EMPTY;
                        out_va   = '0;
                        out_tgt  = '0;
                    end
                    else
                    begin
                        fcmd.pop = 1'b1;
                        out_kind = fdpq_pkg::RES_ISSUE;
                        out_va   = {head_v, {SH{1'b0}}};
                        out_pa   = {head_p, {SH{1'b0}}};
                        out_tgt  = head_t;
                    end
                end
            end
            default: ;
        endcase
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fdpq_pkg::ST_IDLE;
            pend_valid_reg <= 1'b0;
            tq_valid_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            tq_valid_reg   <= tq_valid_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Walk and output payload
    always_ff @(posedge clk)
    begin
        blk_reg       <= blk_next;
        end_blk_reg   <= end_blk_next;
        left_reg      <= left_next;
        tgt_reg       <= tgt_next;
        pend_addr_reg <= pend_addr_next;
        pend_slot_reg <= pend_slot_next;
        if (out_load)
        begin
            out_kind_reg <= out_kind;
            out_va_reg   <= out_va;
            out_pa_reg   <= out_pa;
            out_slot_reg <= out_slot;
            out_tgt_reg  <= out_tgt;
            out_last_reg <= out_last;
        end
    end

    // Table payload: written on allocation, canceled on remove
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TQ_DEPTH; i++)
        begin
            if (state_reg == fdpq_pkg::ST_WALK && out_free && !walk_done && !tq_hit &&
                !fstat.hit && free_found && free_idx == TIW'(i))
            begin
                tq_block_reg[i]  <= query;
                tq_target_reg[i] <= tgt_reg;
                tq_cancel_reg[i] <= 1'b0;
            end
            else if (accept && s_tuser == fdpq_pkg::REQ_REMOVE && squash_reg &&
                     tq_valid_reg[i] && tq_target_reg[i] == in_tgt)
                tq_cancel_reg[i] <= 1'b1;
        end
    end

    fdpq_fifo #(
        .PFQ_DEPTH   (PFQ_DEPTH),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (fcmd),
        .push_v  (tq_block_reg[done_idx]),
        .push_p  (in_phys[AW-1:SH]),
        .push_t  (tq_target_reg[done_idx]),
        .query   (query),
        .del_tgt (tgt_reg),
        .stat    (fstat),
        .head_v  (head_v),
        .head_p  (head_p),
        .head_t  (head_t),
        .count   (fcount)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'd0, out_tgt_reg, out_slot_reg, out_pa_reg, out_va_reg};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fcount) <= PFQ_DEPTH)
        else $error("prefetch FIFO count above depth");

    a_pend_walk: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == fdpq_pkg::ST_WALK))
        else $error("held result outside a walk");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fcount == $past(fcount)) || (fcount == $past(fcount) + CW'(1)) ||
        (fcount + CW'(1) == $past(fcount)))
        else $error("prefetch FIFO count jumped");

    a_walk_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fdpq_pkg::ST_WALK && out_load) |-> out_kind == fdpq_pkg::RES_XLATE)
        else $error("walk produced a non-translation result");
`endif

endmodule

[sv/fdpq_fifo.sv]
// Prefetch FIFO: oldest entry at index 0, block search, push, pop and
// deletion of the first entry of a given target. Depends on fdpq_pkg.
module fdpq_fifo #(
    parameter int PFQ_DEPTH   = fdpq_pkg::PFQ_DEPTH_DEF,
    parameter int BLOCK_BYTES = fdpq_pkg::BLOCK_BYTES_DEF
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  fdpq_pkg::fifo_cmd_t                               cmd,
    input  logic [fdpq_pkg::ADDR_W-$clog2(BLOCK_BYTES)-1:0]   push_v,
    input  logic [fdpq_pkg::ADDR_W-$clog2(BLOCK_BYTES)-1:0]   push_p,
    input  logic [fdpq_pkg::TGT_W-1:0]                        push_t,
    input  logic [fdpq_pkg::ADDR_W-$clog2(BLOCK_BYTES)-1:0]   query,
    input  logic [fdpq_pkg::TGT_W-1:0]                        del_tgt,
    output fdpq_pkg::fifo_stat_t                              stat,
    output logic [fdpq_pkg::ADDR_W-$clog2(BLOCK_BYTES)-1:0]   head_v,
    output logic [fdpq_pkg::ADDR_W-$clog2(BLOCK_BYTES)-1:0]   head_p,
    output logic [fdpq_pkg::TGT_W-1:0]                        head_t,
    output logic [$clog2(PFQ_DEPTH+1)-1:0]                    count
);
    localparam int BN  = fdpq_pkg::ADDR_W - $clog2(BLOCK_BYTES);
    localparam int CW  = $clog2(PFQ_DEPTH + 1);
    localparam int FIW = (PFQ_DEPTH > 1) ? $clog2(PFQ_DEPTH) : 1;

    logic [BN-1:0]                 v_reg [PFQ_DEPTH];
    logic [BN-1:0]                 p_reg [PFQ_DEPTH];
    logic [fdpq_pkg::TGT_W-1:0]    t_reg [PFQ_DEPTH];
    logic [CW-1:0]                 cnt_reg;
    logic [CW-1:0]                 cnt_next;
    logic [FIW-1:0]                del_idx;
    logic [FIW-1:0]                shift_idx;
    logic                          shift_en;
    logic                          hit;
    logic                          del_hit;

    // Parallel search over live entries
    always_comb
    begin
        hit     = 1'b0;
        del_hit = 1'b0;
        del_idx = '0;
        for (int i = 0; i < PFQ_DEPTH; i++)
        begin
            if (CW'(i) < cnt_reg)
            begin
                if (v_reg[i] == query)
                    hit = 1'b1;
                if (!del_hit && t_reg[i] == del_tgt)
                begin
                    del_hit = 1'b1;
                    del_idx = FIW'(i);
                end
            end
        end
    end

    // Shift down from the removed entry
    always_comb
    begin
        shift_en  = 1'b0;
        shift_idx = '0;
        if (cmd.pop && cnt_reg != '0)
            shift_en = 1'b1;
        else if (cmd.del && del_hit)
        begin
            shift_en  = 1'b1;
            shift_idx = del_idx;
        end
        cnt_next = cnt_reg;
        if (shift_en)
            cnt_next = cnt_reg - CW'(1);
        else if (cmd.push)
            cnt_next = cnt_reg + CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // Entry payload, no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PFQ_DEPTH; i++)
        begin
            if (shift_en && FIW'(i) >= shift_idx && i < PFQ_DEPTH - 1)
            begin
                v_reg[i] <= v_reg[(i < PFQ_DEPTH - 1) ? i + 1 : i];
                p_reg[i] <= p_reg[(i < PFQ_DEPTH - 1) ? i + 1 : i];
                t_reg[i] <= t_reg[(i < PFQ_DEPTH - 1) ? i + 1 : i];
            end
            else if (!shift_en && cmd.push && FIW'(i) == cnt_reg[FIW-1:0])
            begin
                v_reg[i] <= push_v;
                p_reg[i] <= push_p;
                t_reg[i] <= push_t;
            end
        end
    end

    assign stat.hit     = hit;
    assign stat.del_hit = del_hit;
    assign stat.empty   = (cnt_reg == '0);
    assign stat.full    = (cnt_reg == CW'(PFQ_DEPTH));
    assign head_v       = v_reg[0];
    assign head_p       = p_reg[0];
    assign head_t       = t_reg[0];
    assign count        = cnt_reg;

endmodule
